// ----- src/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helper functions for the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_RADIX = '0;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_TOP   = 6'd35;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A_MINUS10 = 7'h57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } itrd_state_t;

  // control broadcast to every cell of the digit row
  typedef struct packed {
    logic clear;
    logic shift;
  } itrd_cell_ctl_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] dc;
    dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
    if (dc < DIGIT_TEN) return ASCII_ZERO + {1'b0, dc};
    return ASCII_A_MINUS10 + {1'b0, dc};
  endfunction

endpackage

// ----- src/itrd_if.sv -----
// ----------------------------------------------------------------------------
// itrd_in_if / itrd_out_if
// Valid/ready channels for input values and output digit beats.
// ----------------------------------------------------------------------------
interface itrd_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- src/itrd_cell.sv -----
// ----------------------------------------------------------------------------
// itrd_cell
// One digit of the conversion row: doubles its digit and adds the carry from
// the lower neighbor, reducing mod radix; shifts digits upward for readout.
// ----------------------------------------------------------------------------
module itrd_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [5:0]             radix,
  input  itrd_pkg::itrd_cell_ctl_t ctl,
  input  logic                   act_in,
  input  logic                   carry_in,
  input  logic [5:0]             digit_in,
  output logic                   act_out,
  output logic                   carry_out,
  output logic [5:0]             digit_out
);
  import itrd_pkg::*;

  logic [5:0] digit_r;
  logic       act_r;
  logic       carry_r;
  logic [6:0] sum;
  logic [6:0] diff;
  logic       ge;

  assign sum  = {digit_r, 1'b0} + {6'd0, carry_in};
  assign ge   = (sum >= {1'b0, radix});
  assign diff = sum - {1'b0, radix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      carry_r <= 1'b0;
    end else begin
      act_r   <= act_in & ~ctl.clear;
      carry_r <= act_in & ge & ~ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit_r <= '0;
    end else if (ctl.shift) begin
      digit_r <= digit_in;
    end else if (act_in) begin
      digit_r <= ge ? diff[5:0] : sum[5:0];
    end
  end

  assign act_out   = act_r;
  assign carry_out = carry_r;
  assign digit_out = digit_r;

endmodule

// ----- src/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned value into base-2..36 ASCII digits, MSD first.
// ----------------------------------------------------------------------------
// The value is shifted MSB first into a row of MAX_DIGITS digit cells; each
// cell doubles its digit and passes a registered carry to the next cell, so
// the row runs skewed, each cell a register behind the one below. The digits
// are then shifted out of the top cell one per cycle while the output is not
// stalled: leading zeros are dropped without a beat, then one beat per digit.
// A new value is taken while the final digit beat still waits at the output.
// Radix values outside 2..36 are clamped; values needing more than
// MAX_DIGITS digits give their low MAX_DIGITS digits.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  itrd_in_if.sink                          in_ch,
  itrd_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [itrd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [itrd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import itrd_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + MAX_DIGITS);
  localparam int NW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] FEED_END = CW'(VALUE_BITS);
  localparam logic [CW-1:0] CONV_END = CW'(VALUE_BITS + MAX_DIGITS - 1);
  localparam logic [NW-1:0] NDIG_ALL = NW'(MAX_DIGITS);
  localparam logic [NW-1:0] NDIG_ONE = NW'(1);

  itrd_state_t            state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   sig_r, sig_nxt;
  logic [NW-1:0]          ndig_r, ndig_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [RADIX_W-1:0]     radix_r;

  itrd_cell_ctl_t         ctl;
  logic                   feed_act;
  logic [RADIX_W-1:0]     eff_radix;
  logic                   cfg_wr;
  logic                   reg_hit;

  logic                   act_w   [MAX_DIGITS];
  logic                   carry_w [MAX_DIGITS];
  logic [RADIX_W-1:0]     digit_w [MAX_DIGITS];

  // ---- configuration port
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_RADIX);
  assign cfg_wr  = psel & penable & pwrite & reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  assign eff_radix = clamp_radix(radix_r);

  // ---- digit row
  assign feed_act = (state_r == ST_CONV) && (cnt_r < FEED_END);

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    logic                act_in_k;
    logic                carry_in_k;
    logic [RADIX_W-1:0]  digit_in_k;
    if (k == 0) begin : g_first
      assign act_in_k   = feed_act;
      assign carry_in_k = val_r[VALUE_BITS-1];
      assign digit_in_k = '0;
    end else begin : g_next
      assign act_in_k   = act_w[k-1];
      assign carry_in_k = carry_w[k-1];
      assign digit_in_k = digit_w[k-1];
    end
    itrd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .radix     (eff_radix),
      .ctl       (ctl),
      .act_in    (act_in_k),
      .carry_in  (carry_in_k),
      .digit_in  (digit_in_k),
      .act_out   (act_w[k]),
      .carry_out (carry_w[k]),
      .digit_out (digit_w[k])
    );
  end

  // ---- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sig_r       <= 1'b0;
      ndig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      sig_r       <= sig_nxt;
      ndig_r      <= ndig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    ovf_nxt       = ovf_r;
    sig_nxt       = sig_r;
    ndig_nxt      = ndig_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          val_nxt   = in_ch.value;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          sig_nxt   = 1'b0;
          ndig_nxt  = NDIG_ALL;
          ctl.clear = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (feed_act) val_nxt = {val_r[VALUE_BITS-2:0], 1'b0};
        // carry out of the top cell means digits were dropped
        ovf_nxt = ovf_r | (act_w[MAX_DIGITS-1] & carry_w[MAX_DIGITS-1]);
        if (cnt_r == CONV_END) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sig_r && !ovf_r && (digit_w[MAX_DIGITS-1] == '0) && (ndig_r != NDIG_ONE)) begin
          ctl.shift = 1'b1;
          ndig_nxt  = ndig_r - NW'(1);
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(digit_w[MAX_DIGITS-1]);
          out_last_nxt  = (ndig_r == NDIG_ONE);
          ctl.shift     = 1'b1;
          sig_nxt       = 1'b1;
          ndig_nxt      = ndig_r - NW'(1);
          if (ndig_r == NDIG_ONE) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last_digit = out_last_r;

endmodule

// ----- src/itrd_checker.sv -----
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module itrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] digit_char,
  input logic       last_digit
);
  logic [1:0] pend_r;
  logic       in_beat;
  logic       out_end;

  assign in_beat = in_valid & in_ready;
  assign out_end = out_valid & out_ready & last_digit;

  // items taken whose final digit beat has not gone out yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_end};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
    else $error("output beat changed while stalled");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((digit_char >= 7'h30) && (digit_char <= 7'h39)) ||
                  ((digit_char >= 7'h61) && (digit_char <= 7'h7a)))
    else $error("digit character outside alphabet");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("input taken again before conversion");

  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("digit beat without a pending item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many items in flight");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .digit_char (out_ch.digit_char),
  .last_digit (out_ch.last_digit)
);
